// ===== hw/rtl/blm_pkg.sv =====
// Shared types and constants for the battery level monitor.
// No dependencies; imported by every module of the block.
package blm_pkg;

	localparam int SAMPLE_W    = 14;
	localparam int WINDOW_DEPTH = 8;
	localparam int WIN_IDX_W   = $clog2(WINDOW_DEPTH);
	localparam int SUM_W       = SAMPLE_W + WIN_IDX_W;
	localparam int CORR_W      = 16;
	localparam int LEVEL_W     = 3;
	localparam int CAL_W       = 12;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int NUM_THR     = 4;

	localparam logic [SAMPLE_W-1:0] LENS_OFFSET = 14'd23;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 14'd16383;

	localparam logic [LEVEL_W-1:0] LEVEL_ZERO    = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE     = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO     = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE   = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_FOUR    = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY   = 3'd5;
	localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 3'd7;

	localparam logic [2:0] EMPTY_FIRE = 3'd4;
	localparam logic [2:0] EMPTY_MAX  = 3'd5;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_THR_ONE   = 3'd0;
	localparam logic [2:0] REG_THR_TWO   = 3'd1;
	localparam logic [2:0] REG_THR_THREE = 3'd2;
	localparam logic [2:0] REG_THR_FOUR  = 3'd3;
	localparam logic [2:0] REG_LENS_EN   = 3'd4;
	localparam logic [2:0] REG_CAL       = 3'd5;

	localparam logic [SAMPLE_W-1:0] THR_ONE_RST   = 14'd312;
	localparam logic [SAMPLE_W-1:0] THR_TWO_RST   = 14'd330;
	localparam logic [SAMPLE_W-1:0] THR_THREE_RST = 14'd344;
	localparam logic [SAMPLE_W-1:0] THR_FOUR_RST  = 14'd360;

	typedef struct packed {
		logic [NUM_THR-1:0][SAMPLE_W-1:0] thr;  // thr[0] is threshold one
		logic                             lens_en;
		logic signed [CAL_W-1:0]          cal;
	} blm_cfg_t;

endpackage

// ===== hw/rtl/blm_cfg.sv =====
// APB-style configuration registers of the battery level monitor.
// Depends on blm_pkg; drives the blm_cfg_t bundle used by blm_core.
module blm_cfg
	import blm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output blm_cfg_t           cfg
);

	blm_cfg_t   cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr[0]  <= THR_ONE_RST;
			cfg_q.thr[1]  <= THR_TWO_RST;
			cfg_q.thr[2]  <= THR_THREE_RST;
			cfg_q.thr[3]  <= THR_FOUR_RST;
			cfg_q.lens_en <= 1'b0;
			cfg_q.cal     <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_THR_ONE:   cfg_q.thr[0]  <= pwdata[SAMPLE_W-1:0];
				REG_THR_TWO:   cfg_q.thr[1]  <= pwdata[SAMPLE_W-1:0];
				REG_THR_THREE: cfg_q.thr[2]  <= pwdata[SAMPLE_W-1:0];
				REG_THR_FOUR:  cfg_q.thr[3]  <= pwdata[SAMPLE_W-1:0];
				REG_LENS_EN:   cfg_q.lens_en <= pwdata[0];
				REG_CAL:       cfg_q.cal     <= $signed(pwdata[CAL_W-1:0]);
				default: ;  // unmapped, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_THR_ONE:   prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.thr[0]};
			REG_THR_TWO:   prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.thr[1]};
			REG_THR_THREE: prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.thr[2]};
			REG_THR_FOUR:  prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_q.thr[3]};
			REG_LENS_EN:   prdata = {{(PDATA_W-1){1'b0}}, cfg_q.lens_en};
			REG_CAL:       prdata = {{(PDATA_W-CAL_W){1'b0}}, cfg_q.cal};
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/blm_core.sv =====
// Sample correction, moving-average window, level classifier, debounce and empty count.
// Depends on blm_pkg; state advances once per step, result is combinational.
module blm_core
	import blm_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [ADC_BITS-1:0] sample,
	input  blm_cfg_t            cfg,
	output logic [LEVEL_W-1:0]  level_out,
	output logic [SAMPLE_W-1:0] mean_out
);

	logic [SAMPLE_W-1:0] window_q [WINDOW_DEPTH];
	logic [SUM_W-1:0]    sum_q;
	logic [WIN_IDX_W-1:0] idx_q;
	logic [LEVEL_W-1:0]  prev_q;
	logic [LEVEL_W-1:0]  rep_q;
	logic                odd_q;
	logic [2:0]          empty_q;

	logic signed [CORR_W-1:0] raw_ext, lens_add, cal_half, corr_sum;
	logic [SAMPLE_W-1:0]  corr;
	logic                 first;
	logic [SUM_W-1:0]     sum_n;
	logic [SAMPLE_W-1:0]  mean;
	logic [LEVEL_W-1:0]   level, rep_n;
	logic [2:0]           empty_n;
	logic [WIN_IDX_W-1:0] idx_n;

	// correction: raw + optional lens load + cal/2 rounded toward zero, clamped
	assign raw_ext  = $signed({{(CORR_W-ADC_BITS){1'b0}}, sample});
	assign lens_add = cfg.lens_en ? $signed({2'b00, LENS_OFFSET}) : '0;
	assign cal_half = $signed({{(CORR_W-CAL_W){cfg.cal[CAL_W-1]}}, cfg.cal}
		+ {{(CORR_W-1){1'b0}}, cfg.cal[CAL_W-1]}) >>> 1;
	assign corr_sum = raw_ext + lens_add + cal_half;

	always_comb begin
		priority if (corr_sum < 0)
			corr = '0;
		else if (corr_sum > $signed({2'b00, SAMPLE_MAX}))
			corr = SAMPLE_MAX;
		else
			corr = corr_sum[SAMPLE_W-1:0];
	end

	// first beat after reset seeds the whole window
	assign first = (prev_q == LEVEL_UNKNOWN);

	always_comb begin
		if (first) begin
			sum_n = {corr, {WIN_IDX_W{1'b0}}};
			mean  = corr;
			idx_n = idx_q;
		end else begin
			sum_n = sum_q - {{WIN_IDX_W{1'b0}}, window_q[idx_q]}
				+ {{WIN_IDX_W{1'b0}}, corr};
			mean  = sum_n[SUM_W-1:WIN_IDX_W];
			idx_n = (idx_q == WIN_IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + 1'b1;
		end
	end

	always_comb begin
		priority if (mean > cfg.thr[3]) level = LEVEL_FOUR;
		else if (mean > cfg.thr[2])     level = LEVEL_THREE;
		else if (mean > cfg.thr[1])     level = LEVEL_TWO;
		else if (mean > cfg.thr[0])     level = LEVEL_ONE;
		else                            level = LEVEL_ZERO;
	end

	// odd beats hold back a changed level
	assign rep_n = (!odd_q || level == prev_q || first) ? level : rep_q;

	always_comb begin
		empty_n   = empty_q;
		level_out = rep_n;
		if (empty_q != 3'd0 || rep_n == LEVEL_ZERO) begin
			if (empty_q < EMPTY_MAX)
				empty_n = empty_q + 3'd1;
			if (empty_n == EMPTY_FIRE)
				level_out = LEVEL_EMPTY;
		end
	end

	assign mean_out = mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			idx_q   <= '0;
			prev_q  <= LEVEL_UNKNOWN;
			rep_q   <= LEVEL_ZERO;
			odd_q   <= 1'b0;
			empty_q <= '0;
		end else if (step) begin
			sum_q   <= sum_n;
			idx_q   <= idx_n;
			prev_q  <= level;
			rep_q   <= rep_n;
			odd_q   <= ~odd_q;
			empty_q <= empty_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (first) begin
				for (int i = 0; i < WINDOW_DEPTH; i++)
					window_q[i] <= corr;
			end else begin
				window_q[idx_q] <= corr;
			end
		end
	end

	a_empty_sat: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q <= EMPTY_MAX)
		else $error("empty count beyond saturation");

	a_fresh_state: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q == LEVEL_UNKNOWN |-> idx_q == '0 && !odd_q && empty_q == 3'd0)
		else $error("state moved before the first beat");

	a_prev_known: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> prev_q <= LEVEL_FOUR)
		else $error("previous level not a real level after a beat");

	a_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		step && level_out == LEVEL_EMPTY |=> empty_q == EMPTY_FIRE)
		else $error("empty reported off the fire count");

endmodule

// ===== hw/rtl/battery_level_monitor.sv =====
// Top level of the battery level monitor: input register, result register, handshakes.
// Depends on blm_pkg, blm_cfg and blm_core.
//
// Battery level monitor. Each sample beat carries one raw converter reading;
// the block corrects it (optional lens-load offset, half of the signed
// calibration offset, clamp to 0..16383), keeps an 8-entry moving average,
// classifies the mean against four thresholds into a level 0..4, debounces
// it, and flags empty (level 5) once, on the fourth beat counting the one on
// which the reported level first hits 0. Every sample beat yields exactly
// one result beat carrying battery_level and average_value. Throughput is
// one sample per cycle while results are taken, set by the single combinational
// pass between the input register and the result register, with the window,
// running sum and debounce state updated in that same cycle so back-to-back
// samples see each other's effect. Thresholds, lens enable and calibration
// sit on an APB-style port at byte addresses 0x00..0x14; the user must write
// them only while no sample is in flight, which the block does not enforce.
module battery_level_monitor
	import blm_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,

	// config port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,

	// sample channel
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [ADC_BITS-1:0] adc_sample,

	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output logic [LEVEL_W-1:0]  battery_level,
	output logic [SAMPLE_W-1:0] average_value
);

	blm_cfg_t            cfg;
	logic                vld_s1;
	logic [ADC_BITS-1:0] sample_s1;
	logic                res_vld_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic                adv;
	logic [LEVEL_W-1:0]  core_level;
	logic [SAMPLE_W-1:0] core_mean;

	blm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves into the result register when that one is free or draining
	assign adv          = vld_s1 && (!res_vld_q || result_ready);
	assign sample_ready = !vld_s1 || adv;

	blm_core #(
		.ADC_BITS (ADC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.sample    (sample_s1),
		.cfg       (cfg),
		.level_out (core_level),
		.mean_out  (core_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (sample_ready)
				vld_s1 <= sample_valid;
			if (adv)
				res_vld_q <= 1'b1;
			else if (result_ready)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid)
			sample_s1 <= adc_sample;
		if (adv) begin
			level_q <= core_level;
			mean_q  <= core_mean;
		end
	end

	assign result_valid  = res_vld_q;
	assign battery_level = level_q;
	assign average_value = mean_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(sample_s1))
		else $error("stage 1 beat lost while stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> battery_level <= LEVEL_EMPTY)
		else $error("result level out of range");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("advanced beat missing from result register");

endmodule
